### rtl/hsvq_pkg.sv
// Shared widths, constants, stage payload types and helpers for the HSV to RGB converter.
package hsvq_pkg;

  localparam int unsigned Q_W    = 17;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned CHAN_W = 8;

  localparam logic [Q_W-1:0] Q16_ONE = 17'h10000;

  // Sextants of the hue circle, in the order of the usual walk.
  typedef enum logic [2:0] {
    SX_RED_YEL = 3'd0,
    SX_YEL_GRN = 3'd1,
    SX_GRN_CYN = 3'd2,
    SX_CYN_BLU = 3'd3,
    SX_BLU_MAG = 3'd4,
    SX_MAG_RED = 3'd5
  } sext_t;

  // After clamping and splitting the hue.
  typedef struct packed {
    sext_t             sect;
    logic [FRAC_W-1:0] frac;
    logic [Q_W-1:0]    sat;
    logic [Q_W-1:0]    val;
  } s1_t;

  // Saturation products.
  typedef struct packed {
    sext_t             sect;
    logic [Q_W-1:0]    val;
    logic [Q_W-1:0]    oms;
    logic [FRAC_W-1:0] sf;
    logic [Q_W-1:0]    sof;
  } s2_t;

  // The three intermediate levels beside the value itself.
  typedef struct packed {
    sext_t          sect;
    logic [Q_W-1:0] val;
    logic [Q_W-1:0] p;
    logic [Q_W-1:0] q;
    logic [Q_W-1:0] t;
  } s3_t;

  // Scales a Q16 level (at most one) to 0..255: (x*255) >> 16, done as (x<<8) - x.
  function automatic logic [CHAN_W-1:0] to_chan(input logic [Q_W-1:0] x);
    logic [Q_W+CHAN_W-1:0] m;
    m = {x, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, x};
    return m[FRAC_W+CHAN_W-1:FRAC_W];
  endfunction

endpackage

### rtl/hsvq_if.sv
// Valid/ready stream interfaces for the pixel input and the colour output.
interface hsvq_in_if;
  import hsvq_pkg::*;
  logic           valid;
  logic           ready;
  logic [Q_W-1:0] hue;
  logic [Q_W-1:0] saturation;
  logic [Q_W-1:0] brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsvq_out_if;
  import hsvq_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

### rtl/hsvq_front.sv
// First stage: clamps the inputs and splits the hue into sextant and fraction.
module hsvq_front (
  input  logic            clk,
  input  logic            rst_n,
  hsvq_in_if.sink         in_beat,
  input  logic            dn_ready,
  output logic            dn_valid,
  output hsvq_pkg::s1_t   dn_data
);
  import hsvq_pkg::*;

  logic                valid_r;
  s1_t                 data_r;
  s1_t                 data_nxt;
  logic [FRAC_W-1:0]   hue_c;
  logic [FRAC_W+2:0]   h6;

  assign in_beat.ready = !valid_r || dn_ready;

  always_comb begin
    hue_c = in_beat.hue[FRAC_W] ? {FRAC_W{1'b1}} : in_beat.hue[FRAC_W-1:0];
    h6    = {1'b0, hue_c, 2'b00} + {2'b00, hue_c, 1'b0};
    data_nxt.sect = sext_t'(h6[FRAC_W+2:FRAC_W]);
    data_nxt.frac = h6[FRAC_W-1:0];
    data_nxt.sat  = (in_beat.saturation > Q16_ONE) ? Q16_ONE : in_beat.saturation;
    data_nxt.val  = (in_beat.brightness > Q16_ONE) ? Q16_ONE : in_beat.brightness;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_beat.ready) begin
      valid_r <= in_beat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat.ready && in_beat.valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

### rtl/hsvq_satmul.sv
// Second stage: one minus the saturation, and saturation times the sextant fraction and times its complement.
module hsvq_satmul (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  hsvq_pkg::s1_t   up_data,
  input  logic            dn_ready,
  output logic            dn_valid,
  output hsvq_pkg::s2_t   dn_data
);
  import hsvq_pkg::*;

  logic                   valid_r;
  s2_t                    data_r;
  s2_t                    data_nxt;
  logic [Q_W-1:0]         omf;
  logic [Q_W+FRAC_W-1:0]  sf_full;
  logic [2*Q_W-1:0]       sof_full;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    omf      = Q16_ONE - {1'b0, up_data.frac};
    sf_full  = up_data.sat * up_data.frac;
    sof_full = up_data.sat * omf;
    data_nxt.sect = up_data.sect;
    data_nxt.val  = up_data.val;
    data_nxt.oms  = Q16_ONE - up_data.sat;
    data_nxt.sf   = sf_full[FRAC_W+FRAC_W-1:FRAC_W];
    data_nxt.sof  = sof_full[FRAC_W+Q_W-1:FRAC_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

### rtl/hsvq_level.sv
// Third stage: forms the p, q and t levels from the value.
module hsvq_level (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  hsvq_pkg::s2_t   up_data,
  input  logic            dn_ready,
  output logic            dn_valid,
  output hsvq_pkg::s3_t   dn_data
);
  import hsvq_pkg::*;

  logic              valid_r;
  s3_t               data_r;
  s3_t               data_nxt;
  logic [Q_W-1:0]    q_fac;
  logic [Q_W-1:0]    t_fac;
  logic [2*Q_W-1:0]  p_full;
  logic [2*Q_W-1:0]  q_full;
  logic [2*Q_W-1:0]  t_full;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    q_fac  = Q16_ONE - {1'b0, up_data.sf};
    t_fac  = Q16_ONE - up_data.sof;
    p_full = up_data.val * up_data.oms;
    q_full = up_data.val * q_fac;
    t_full = up_data.val * t_fac;
    data_nxt.sect = up_data.sect;
    data_nxt.val  = up_data.val;
    data_nxt.p    = p_full[FRAC_W+Q_W-1:FRAC_W];
    data_nxt.q    = q_full[FRAC_W+Q_W-1:FRAC_W];
    data_nxt.t    = t_full[FRAC_W+Q_W-1:FRAC_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

### rtl/hsvq_mix.sv
// Last stage: picks the levels per sextant, scales them to 8 bits and holds the output beat.
module hsvq_mix (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  hsvq_pkg::s3_t   up_data,
  hsvq_out_if.source      out_beat
);
  import hsvq_pkg::*;

  logic              valid_r;
  logic [CHAN_W-1:0] red_r,   red_nxt;
  logic [CHAN_W-1:0] green_r, green_nxt;
  logic [CHAN_W-1:0] blue_r,  blue_nxt;
  logic [Q_W-1:0]    r_lvl, g_lvl, b_lvl;

  assign up_ready = !valid_r || out_beat.ready;

  always_comb begin
    unique case (up_data.sect)
      SX_RED_YEL: begin r_lvl = up_data.val; g_lvl = up_data.t;   b_lvl = up_data.p;   end
      SX_YEL_GRN: begin r_lvl = up_data.q;   g_lvl = up_data.val; b_lvl = up_data.p;   end
      SX_GRN_CYN: begin r_lvl = up_data.p;   g_lvl = up_data.val; b_lvl = up_data.t;   end
      SX_CYN_BLU: begin r_lvl = up_data.p;   g_lvl = up_data.q;   b_lvl = up_data.val; end
      SX_BLU_MAG: begin r_lvl = up_data.t;   g_lvl = up_data.p;   b_lvl = up_data.val; end
      default:    begin r_lvl = up_data.val; g_lvl = up_data.p;   b_lvl = up_data.q;   end
    endcase
    red_nxt   = to_chan(r_lvl);
    green_nxt = to_chan(g_lvl);
    blue_nxt  = to_chan(b_lvl);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_beat.valid = valid_r;
  assign out_beat.red   = red_r;
  assign out_beat.green = green_r;
  assign out_beat.blue  = blue_r;

endmodule

### rtl/hsv_to_rgb_q16_top.sv
// Top level of the Q16 HSV to 8-bit RGB converter pipeline.
//
//   Channel    Dir  Fields                           Handshake
//   in_beat    in   hue, saturation, brightness (17) valid/ready
//   out_beat   out  red, green, blue (8)             valid/ready
//
// Four register stages: clamp and split hue, saturation products, levels,
// then selection and scaling into the output register.
// Beats pass in order; one beat per cycle while the output is not stalled.
// Reset clears the valid bits of every stage; payload registers are not reset.
// Each stage takes a beat when it is empty or its successor takes its own,
// so bubbles are filled while the output is stalled.
module hsv_to_rgb_q16_top (
  input  logic        clk,
  input  logic        rst_n,
  hsvq_in_if.sink     in_beat,
  hsvq_out_if.source  out_beat
);
  import hsvq_pkg::*;

  logic s1_valid, s2_valid, s3_valid;
  logic s2_ready, s3_ready, s4_ready;
  s1_t  s1_data;
  s2_t  s2_data;
  s3_t  s3_data;

  hsvq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (in_beat),
    .dn_ready (s2_ready),
    .dn_valid (s1_valid),
    .dn_data  (s1_data)
  );

  hsvq_satmul u_satmul (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s2_ready),
    .up_data  (s1_data),
    .dn_ready (s3_ready),
    .dn_valid (s2_valid),
    .dn_data  (s2_data)
  );

  hsvq_level u_level (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s3_ready),
    .up_data  (s2_data),
    .dn_ready (s4_ready),
    .dn_valid (s3_valid),
    .dn_data  (s3_data)
  );

  hsvq_mix u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s3_valid),
    .up_ready (s4_ready),
    .up_data  (s3_data),
    .out_beat (out_beat)
  );

  // The input is only refused when every stage is full and the output is stalled.
  a_full_when_refused: assert property (@(posedge clk) disable iff (!rst_n)
    !in_beat.ready |-> (s1_valid && s2_valid && s3_valid && out_beat.valid && !out_beat.ready))
    else $error("input refused while the pipeline has room");

  // A stalled third stage keeps its beat unchanged.
  a_level_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_valid && !s4_ready) |=> (s3_valid && $stable(s3_data)))
    else $error("third stage lost or changed a stalled beat");

  // A stalled second stage keeps its beat unchanged.
  a_satmul_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid && !s3_ready) |=> (s2_valid && $stable(s2_data)))
    else $error("second stage lost or changed a stalled beat");

endmodule
